/* hw/rtl/bmhq_pkg.sv */
package bmhq_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic signed [DATA_W-1:0] val;
	} cmd_t;

endpackage

/* hw/rtl/bmhq_in_if.sv */
interface bmhq_in_if;
	import bmhq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);

endinterface

/* hw/rtl/bmhq_out_if.sv */
interface bmhq_out_if;
	import bmhq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DATA_W-1:0]  removed_value;
	logic        [STAT_W-1:0]  status;
	logic        [COUNT_W-1:0] count;
	logic signed [DATA_W-1:0]  current_min;
	logic                      is_empty;

	modport source (output valid, output removed_value, output status, output count,
		output current_min, output is_empty, input ready);
	modport sink   (input valid, input removed_value, input status, input count,
		input current_min, input is_empty, output ready);

endinterface

/* hw/rtl/bmhq_cell.sv */
module bmhq_cell
	import bmhq_pkg::*;
(
	input  logic                     clk,
	input  cmd_t                     cmd,
	input  logic                     occ,
	input  logic                     left_le,
	input  logic signed [DATA_W-1:0] left_val,
	input  logic signed [DATA_W-1:0] right_val,
	output logic                     le,
	output logic signed [DATA_W-1:0] val
);

	logic signed [DATA_W-1:0] val_q;

	// held entry stays put if it is not above the new value
	assign le  = occ && !(cmd.val < val_q);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (le) begin
				val_q <= val_q;
			end else if (left_le) begin
				val_q <= cmd.val;
			end else begin
				val_q <= left_val;
			end
		end else if (cmd.rem) begin
			val_q <= right_val;
		end
	end

endmodule

/* hw/rtl/binary_min_heap_queue.sv */
// Priority queue held as a sorted row of cells, smallest at the head.
// Result is registered and valid in the cycle after the input transaction.
// Throughput: one transaction per cycle unless a held result is not yet taken by
// rsp.ready; each cell compares once and shifts with its neighbor in that same cycle.
// Reset clears the entry count and the result valid; cell contents are
// left undefined and are only read below the count.
module binary_min_heap_queue
	import bmhq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bmhq_in_if.sink    req,
	bmhq_out_if.source rsp
);

	logic [CNT_W-1:0]         count_q;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] removed_q;
	logic [STAT_W-1:0]        status_q;
	logic [CNT_W-1:0]         rcount_q;
	logic signed [DATA_W-1:0] min_q;
	logic                     empty_q;

	logic                     acc;
	logic                     full;
	logic                     empty;
	cmd_t                     cmd;
	logic signed [DATA_W-1:0] cell_val [CAPACITY];
	logic                     cell_le  [CAPACITY];

	logic signed [DATA_W-1:0] removed_d;
	logic [STAT_W-1:0]        status_d;
	logic [CNT_W-1:0]         count_d;
	logic signed [DATA_W-1:0] min_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);

	assign cmd.ins = acc && (req.opcode == OP_INSERT) && !full;
	assign cmd.rem = acc && (req.opcode == OP_REMOVE) && !empty;
	assign cmd.val = req.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     l_le;
		logic signed [DATA_W-1:0] l_val;
		logic signed [DATA_W-1:0] r_val;

		if (i == 0) begin : g_head
			assign l_le  = 1'b1;
			assign l_val = '0;
		end else begin : g_body
			assign l_le  = cell_le[i-1];
			assign l_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_val = cell_val[i];
		end else begin : g_mid
			assign r_val = cell_val[i+1];
		end

		bmhq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (CNT_W'(i) < count_q),
			.left_le   (l_le),
			.left_val  (l_val),
			.right_val (r_val),
			.le        (cell_le[i]),
			.val       (cell_val[i])
		);
	end

	always_comb begin
		removed_d = '0;
		status_d  = ST_OK;
		count_d   = count_q;
		min_d     = empty ? '0 : cell_val[0];
		if (req.opcode == OP_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
				if (empty || (req.value < cell_val[0])) begin
					min_d = req.value;
				end
			end
		end else begin
			if (empty) begin
				removed_d = -32'sd1;
				status_d  = ST_EMPTY;
			end else begin
				removed_d = cell_val[0];
				count_d   = count_q - CNT_W'(1);
				min_d     = (count_q > CNT_W'(1)) ? cell_val[1] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			removed_q <= removed_d;
			status_q  <= status_d;
			rcount_q  <= count_d;
			min_q     <= min_d;
			empty_q   <= (count_d == '0);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = removed_q;
	assign rsp.status        = status_q;
	assign rsp.count         = COUNT_W'(rcount_q);
	assign rsp.current_min   = min_q;
	assign rsp.is_empty      = empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CNT_W'(1)) |-> !(cell_val[1] < cell_val[0]))
		else $error("head cell not the minimum");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.opcode == OP_REMOVE && !empty) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not drop the count");

	a_rsp_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		(acc) |=> (rsp.valid && rcount_q == count_q))
		else $error("reported count differs from held count");

endmodule
